FILE: design/udct_pkg.sv
// Shared types, constants and helpers for the UTF-8 display column tracker.
// No dependencies; imported by utf8_display_column_tracker_top.
package udct_pkg;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COL_W   = 16;
  localparam int unsigned IDX_W   = 13;
  localparam int unsigned TAB_W   = 5;
  localparam int unsigned SKIP_W  = 2;

  // Default line length limit and hard index limit of the 13-bit field
  localparam int unsigned MAX_LINE_BYTES_DEF = 4096;
  localparam int unsigned IDX_FIELD_MAX      = 8191;

  // Register reset values
  localparam logic [TAB_W-1:0] TAB_STOP_RST = 5'd8;
  localparam logic [COL_W-1:0] TARGET_RST   = 16'd0;

  // Configuration register indexes
  localparam logic CFG_TAB_STOP = 1'b0;
  localparam logic CFG_TARGET   = 1'b1;

  // Special bytes and UTF-8 lead patterns
  localparam logic [BYTE_W-1:0] TAB_CHAR   = 8'h09;
  localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
  localparam logic [BYTE_W-1:0] MASK_2B    = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_2B    = 8'hC0;
  localparam logic [BYTE_W-1:0] MASK_3B    = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD_3B    = 8'hE0;
  localparam logic [BYTE_W-1:0] MASK_4B    = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD_4B    = 8'hF0;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_TADJ = 4'b0100,
    S_CALC = 4'b1000
  } state_t;

  // Number of continuation bytes that follow a lead byte
  function automatic logic [SKIP_W-1:0] lead_skip(input logic [BYTE_W-1:0] b);
    logic [SKIP_W-1:0] s;
    s = 2'd0;
    if ((b & ASCII_MASK) == 8'h00)   s = 2'd0;
    else if ((b & MASK_2B) == LEAD_2B) s = 2'd1;
    else if ((b & MASK_3B) == LEAD_3B) s = 2'd2;
    else if ((b & MASK_4B) == LEAD_4B) s = 2'd3;
    else s = 2'd0;
    return s;
  endfunction

endpackage

FILE: design/utf8_display_column_tracker_top.sv
// UTF-8 display column tracker with tab stops: top level and sequencer.
// Depends on udct_pkg.
//
//  channel  direction  handshake           payload
//  -------  ---------  ------------------  ----------------------------------------------
//  in       sink       in_valid/in_stall   text_byte, end_of_line
//  out      source     out_valid/out_stall column, char_start, target_byte_index, final_res
//  cfg      sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// An ordinary byte is accepted, then updated; a tab at the start
// of a character is accepted, then takes 16 remainder steps of the shared add/subtract unit, one
// step to form the distance to the next stop, then the column update.
// A finished item goes to the output register; the next item is taken while it waits.
// The update step holds while the output register is full and stalled.
// rst is synchronous; it clears line state, sequencer and output valid, and sets the
// registers to tab_stop 8 and target_column 0.
module utf8_display_column_tracker_top
  import udct_pkg::*;
#(
  parameter int unsigned MAX_LINE_BYTES = MAX_LINE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // input items
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [BYTE_W-1:0]   text_byte,
  input  logic                end_of_line,
  // result items
  output logic                out_valid,
  input  logic                out_stall,
  output logic [COL_W-1:0]    column,
  output logic                char_start,
  output logic [IDX_W-1:0]    target_byte_index,
  output logic                final_res,
  // configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [COL_W-1:0]    cfg_data
);

  localparam int unsigned IDX_CAP =
    (MAX_LINE_BYTES > IDX_FIELD_MAX) ? IDX_FIELD_MAX : MAX_LINE_BYTES;
  localparam logic [IDX_W-1:0] IDX_CAP_V = IDX_W'(IDX_CAP);
  localparam int unsigned BITCNT_W = $clog2(COL_W);
  localparam int unsigned ALU_W = COL_W + 2;

  // Configuration registers
  logic [TAB_W-1:0] tab_stop;
  logic [COL_W-1:0] target_column;

  // Line state
  logic [COL_W-1:0]  running_column;
  logic [SKIP_W-1:0] bytes_to_skip;
  logic [IDX_W-1:0]  byte_count;
  logic              target_seen;
  logic [IDX_W-1:0]  found_index;

  // Sequencer and working registers
  state_t              state, state_next;
  logic [BYTE_W-1:0]   cur_byte;
  logic                cur_last;
  logic [TAB_W-1:0]    rem;
  logic [BITCNT_W-1:0] bit_cnt;

  // Shared add/subtract unit
  logic [ALU_W-1:0] alu_a, alu_b, alu_res;
  logic             alu_sub;

  logic [TAB_W-1:0]  ts_eff;
  logic [TAB_W:0]    rem_shift;
  logic              in_accept;
  logic              out_free;
  logic              cur_start;
  logic              cur_tab;
  logic [COL_W:0]    col_sum;
  logic [COL_W-1:0]  col_sat;
  logic              hit;
  logic              seen_next;
  logic [IDX_W-1:0]  found_next;
  logic [IDX_W-1:0]  len_next;
  logic [IDX_W-1:0]  result_index;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign ts_eff    = (tab_stop == '0) ? TAB_W'(1) : tab_stop;
  assign rem_shift = {rem, running_column[bit_cnt]};
  assign cur_start = (bytes_to_skip == '0);
  assign cur_tab   = (cur_byte == TAB_CHAR);

  // Operand select for the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      S_DIV: begin
        alu_a   = ALU_W'(rem_shift);
        alu_b   = ALU_W'(ts_eff);
        alu_sub = 1'b1;
      end
      S_TADJ: begin
        alu_a   = ALU_W'(ts_eff);
        alu_b   = ALU_W'(rem);
        alu_sub = 1'b1;
      end
      S_CALC: begin
        alu_a = ALU_W'(running_column);
        if (cur_tab) begin
          alu_b = ALU_W'(rem);
        end else if ((cur_byte & ASCII_MASK) == 8'h00) begin
          alu_b = ALU_W'(1);
        end else begin
          alu_b = ALU_W'(2);
        end
      end
      S_IDLE: begin
        alu_a = '0;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

  // Column update, target search and result index
  always_comb begin
    col_sum = alu_res[COL_W:0];
    col_sat  = col_sum[COL_W] ? {COL_W{1'b1}} : col_sum[COL_W-1:0];
    hit      = cur_start && !target_seen && (target_column != '0) &&
               (col_sum > {1'b0, target_column});
    seen_next  = target_seen || hit;
    found_next = hit ? byte_count : found_index;
    len_next   = (byte_count >= IDX_CAP_V) ? IDX_CAP_V : (byte_count + IDX_W'(1));
    if (!cur_last || target_column == '0) begin
      result_index = '0;
    end else if (seen_next) begin
      result_index = found_next;
    end else begin
      result_index = len_next;
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = (cur_start && text_byte == TAB_CHAR) ? S_DIV : S_CALC;
        end
      end
      S_DIV: begin
        if (bit_cnt == '0) state_next = S_TADJ;
      end
      S_TADJ: state_next = S_CALC;
      S_CALC: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tab_stop      <= TAB_STOP_RST;
      target_column <= TARGET_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TAB_STOP: tab_stop      <= cfg_data[TAB_W-1:0];
        CFG_TARGET:   target_column <= cfg_data;
        default:      tab_stop      <= tab_stop;
      endcase
    end
  end

  // Item capture and remainder iteration
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_byte <= text_byte;
      cur_last <= end_of_line;
      rem      <= '0;
      bit_cnt  <= BITCNT_W'(COL_W - 1);
    end else if (state == S_DIV) begin
      // restoring step: keep the difference when it does not go negative
      rem     <= alu_res[ALU_W-1] ? rem_shift[TAB_W-1:0] : alu_res[TAB_W-1:0];
      bit_cnt <= bit_cnt - BITCNT_W'(1);
    end else if (state == S_TADJ) begin
      // distance to the next tab stop
      rem <= alu_res[TAB_W-1:0];
    end
  end

  // Line state update
  always_ff @(posedge clk) begin
    if (rst) begin
      running_column <= '0;
      bytes_to_skip  <= '0;
      byte_count     <= '0;
      target_seen    <= 1'b0;
      found_index    <= '0;
    end else if (state == S_CALC && out_free) begin
      if (cur_last) begin
        running_column <= '0;
        bytes_to_skip  <= '0;
        byte_count     <= '0;
        target_seen    <= 1'b0;
        found_index    <= '0;
      end else begin
        if (cur_start) begin
          running_column <= col_sat;
          bytes_to_skip  <= lead_skip(cur_byte);
        end else begin
          bytes_to_skip  <= bytes_to_skip - SKIP_W'(1);
        end
        byte_count  <= len_next;
        target_seen <= seen_next;
        found_index <= found_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_CALC && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CALC && out_free) begin
      column            <= cur_start ? col_sat : running_column;
      char_start        <= cur_start;
      target_byte_index <= result_index;
      final_res         <= cur_last;
    end
  end

  // Checks
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    byte_count <= IDX_CAP_V)
    else $error("byte count past cap");

  a_found_order: assert property (@(posedge clk) disable iff (rst)
    target_seen |-> (found_index <= byte_count))
    else $error("found index beyond bytes seen");

  a_tab_divides: assert property (@(posedge clk) disable iff (rst)
    (in_accept && cur_start && text_byte == TAB_CHAR) |=> (state == S_DIV))
    else $error("tab did not start remainder steps");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < ts_eff))
    else $error("remainder not below tab stop");

  a_out_from_calc: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_CALC))
    else $error("result loaded outside update step");

endmodule

FILE: tb/tb_utf8_display_column_tracker_top.sv
// Self-checking testbench for utf8_display_column_tracker_top: directed table, then random lines.
// Depends on udct_pkg and the tracker RTL; results are predicted in-bench and checked in order.
module tb_utf8_display_column_tracker_top;
  import udct_pkg::*;

  localparam int unsigned IDX_CAP = (MAX_LINE_BYTES_DEF > IDX_FIELD_MAX) ?
                                    IDX_FIELD_MAX : MAX_LINE_BYTES_DEF;
  localparam int unsigned COL_SAT      = 65535;
  localparam int          DRAIN_CYCLES = 24;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          RANDOM_ITEMS = 1580;
  localparam int          QUIET_FIRST  = 700;
  localparam int          QUIET_LAST   = 1000;
  localparam int          HOLD_AT      = 400;
  localparam int          PAUSE_AT     = 1250;
  localparam int          LIMIT_TIME   = 24000000;

  // One result item as the block reports it
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             start;
    logic [IDX_W-1:0] idx;
    logic             fin;
  } col_result_t;

  // Rows of the directed table
  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;
  typedef struct packed {
    row_kind_t        kind;
    logic             reg_idx;
    logic [COL_W-1:0] data;
    logic [7:0]       b;
    logic             eol;
    logic [12:0]      reps;
    logic             typed;
    col_result_t      want;
  } stim_row_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       text_byte;
  logic             end_of_line;
  logic             out_valid;
  logic             out_stall;
  logic [COL_W-1:0] column;
  logic             char_start;
  logic [IDX_W-1:0] target_byte_index;
  logic             final_res;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_index;
  logic [COL_W-1:0] cfg_data;

  utf8_display_column_tracker_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .text_byte(text_byte), .end_of_line(end_of_line),
    .out_valid(out_valid), .out_stall(out_stall),
    .column(column), .char_start(char_start),
    .target_byte_index(target_byte_index), .final_res(final_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Bench copy of registers and line state
  logic [TAB_W-1:0] tab_cfg;
  logic [COL_W-1:0] target_cfg;
  int unsigned      col_run;
  logic [1:0]       skip_left;
  int unsigned      bytes_seen;
  bit               hit_found;
  int unsigned      hit_index;

  col_result_t expected_columns[$];
  stim_row_t   dir_rows[$];

  int  items_sent;
  int  directed_items;
  int  lines_sent;
  int  cfg_writes;
  int  results_checked;
  int  mismatches;
  bit  no_idle;
  bit  hold_request;
  int  hold_left;
  bit  hold_done;

  // Continuation bytes that follow a lead byte
  function automatic logic [1:0] extra_bytes(input logic [7:0] b);
    casez (b)
      8'b0???????: return 2'd0;
      8'b110?????: return 2'd1;
      8'b1110????: return 2'd2;
      8'b11110???: return 2'd3;
      default:     return 2'd0;
    endcase
  endfunction

  // Advance line state by one byte and return the result it causes
  function automatic col_result_t predict_columns(input logic [7:0] b, input logic eol);
    col_result_t r;
    int unsigned stop, nxt, here, len;
    r = '0;
    here = bytes_seen;
    r.start = (skip_left == 2'd0);
    if (r.start) begin
      stop = (tab_cfg == 0) ? 1 : tab_cfg;
      skip_left = extra_bytes(b);
      if (b == TAB_CHAR) nxt = (col_run / stop + 1) * stop;
      else if ((b & ASCII_MASK) == 8'h00) nxt = col_run + 1;
      else nxt = col_run + 2;
      // target compare uses the unsaturated end column
      if (!hit_found && target_cfg != 0 && nxt > target_cfg) begin
        hit_found = 1'b1;
        hit_index = here;
      end
      col_run = (nxt > COL_SAT) ? COL_SAT : nxt;
    end else begin
      skip_left = skip_left - 2'd1;
    end
    len = (here + 1 > IDX_CAP) ? IDX_CAP : here + 1;
    bytes_seen = len;
    r.col = col_run[COL_W-1:0];
    r.fin = eol;
    if (eol) begin
      if (target_cfg == 0) r.idx = '0;
      else if (hit_found) r.idx = hit_index[IDX_W-1:0];
      else r.idx = len[IDX_W-1:0];
      col_run    = 0;
      skip_left  = 2'd0;
      bytes_seen = 0;
      hit_found  = 1'b0;
      hit_index  = 0;
    end
    return r;
  endfunction

  function automatic stim_row_t byte_row(input logic [7:0] b, input logic eol,
                                         input logic [12:0] reps);
    stim_row_t r;
    r = '0;
    r.kind = ROW_BYTE;
    r.b = b;
    r.eol = eol;
    r.reps = reps;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [7:0] b, input logic eol,
                                          input col_result_t want);
    stim_row_t r;
    r = byte_row(b, eol, 13'd1);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic idx, input logic [COL_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.data = data;
    return r;
  endfunction

  // Target mix: mostly small so short lines hit it, plus the extremes
  function automatic logic [COL_W-1:0] pick_target();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 16'hFFFF;
      2, 3:    return COL_W'($urandom_range(0, 65535));
      default: return COL_W'($urandom_range(1, 80));
    endcase
  endfunction

  // Offer one item, with an occasional idle gap first; predict on acceptance
  task automatic send_byte(input logic [7:0] b, input logic eol, input bit typed,
                           input col_result_t want);
    col_result_t pred;
    if (!no_idle && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    text_byte   <= b;
    end_of_line <= eol;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_columns(b, eol);
    expected_columns.push_back(typed ? want : pred);
    items_sent++;
    if (eol) lines_sent++;
  endtask

  // Stop offering until every expected result is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_columns.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write, only with the block idle
  task automatic write_reg(input logic idx, input logic [COL_W-1:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_TAB_STOP) tab_cfg = data[TAB_W-1:0];
    else target_cfg = data;
    cfg_writes++;
    @(posedge clk);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #(LIMIT_TIME);
    $display("Regression FAIL");
    $finish;
  end

  // Result side: random stalls, one long hold, in-order checking
  initial begin
    col_result_t act, want;
    out_stall = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        act = '{column, char_start, target_byte_index, final_res};
        if (expected_columns.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: col=%0d start=%0b idx=%0d fin=%0b",
                     act.col, act.start, act.idx, act.fin);
        end else begin
          want = expected_columns.pop_front();
          results_checked++;
          if (act.col !== want.col || act.start !== want.start ||
              act.idx !== want.idx || act.fin !== want.fin) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch #%0d: exp col=%0d start=%0b idx=%0d fin=%0b, ",
                        "got col=%0d start=%0b idx=%0d fin=%0b"},
                       results_checked, want.col, want.start, want.idx, want.fin,
                       act.col, act.start, act.idx, act.fin);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (!no_idle && $urandom_range(99) < 8);
      end
    end
  end

  // Stimulus
  initial begin
    logic [7:0] line_bytes[$];
    int         n_chars, kind, rand_items, cut;
    bit         pause_done;
    col_result_t none;

    rst          = 1'b1;
    in_valid     = 1'b0;
    text_byte    = '0;
    end_of_line  = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_TAB_STOP;
    cfg_data     = '0;
    tab_cfg      = TAB_STOP_RST;
    target_cfg   = TARGET_RST;
    col_run      = 0;
    skip_left    = 2'd0;
    bytes_seen   = 0;
    hit_found    = 1'b0;
    hit_index    = 0;
    items_sent   = 0;
    lines_sent   = 0;
    cfg_writes   = 0;
    results_checked = 0;
    mismatches   = 0;
    no_idle      = 1'b0;
    hold_request = 1'b0;
    pause_done   = 1'b0;
    rand_items   = 0;
    none         = '0;

    // Directed table: reset values, lead patterns, tab stops, truncation, extremes
    dir_rows.push_back(typed_row("A",     1'b1, '{16'd1, 1'b1, 13'd0, 1'b1}));
    dir_rows.push_back(typed_row(8'h00,   1'b1, '{16'd1, 1'b1, 13'd0, 1'b1}));
    dir_rows.push_back(typed_row(8'hFF,   1'b1, '{16'd2, 1'b1, 13'd0, 1'b1}));
    dir_rows.push_back(typed_row(8'h80,   1'b1, '{16'd2, 1'b1, 13'd0, 1'b1}));
    dir_rows.push_back(typed_row(TAB_CHAR, 1'b1, '{16'd8, 1'b1, 13'd0, 1'b1}));
    // zero tab stop acts as one; upper data bits ignored
    dir_rows.push_back(cfg_row(CFG_TAB_STOP, 16'hFFE0));
    dir_rows.push_back(byte_row("a", 1'b0, 13'd1));
    dir_rows.push_back(byte_row(TAB_CHAR, 1'b1, 13'd1));
    // 2-, 3-byte chars, then a 4-byte lead cut short by end of line
    dir_rows.push_back(cfg_row(CFG_TARGET, 16'd3));
    dir_rows.push_back(byte_row(8'hC3, 1'b0, 13'd1));
    dir_rows.push_back(byte_row(8'hA9, 1'b0, 13'd1));
    dir_rows.push_back(byte_row(8'hE2, 1'b0, 13'd1));
    dir_rows.push_back(byte_row(8'h82, 1'b0, 13'd1));
    dir_rows.push_back(byte_row(8'hAC, 1'b0, 13'd1));
    dir_rows.push_back(byte_row(8'hF0, 1'b0, 13'd1));
    dir_rows.push_back(byte_row(8'h9F, 1'b1, 13'd1));
    // target changes between bytes of one line
    dir_rows.push_back(byte_row("a", 1'b0, 13'd1));
    dir_rows.push_back(cfg_row(CFG_TARGET, 16'd1));
    dir_rows.push_back(byte_row(8'hF8, 1'b1, 13'd1));
    // widest tab stop against the top target
    dir_rows.push_back(cfg_row(CFG_TAB_STOP, 16'h001F));
    dir_rows.push_back(cfg_row(CFG_TARGET, 16'hFFFF));
    dir_rows.push_back(byte_row(TAB_CHAR, 1'b0, 13'd20));
    dir_rows.push_back(byte_row("x", 1'b1, 13'd1));
    // no hit, so the line length comes back
    dir_rows.push_back(byte_row("a", 1'b0, 13'd30));
    dir_rows.push_back(typed_row("b", 1'b1, '{16'd31, 1'b1, 13'd31, 1'b1}));
    // tab stop above 16 used as given
    dir_rows.push_back(cfg_row(CFG_TAB_STOP, 16'h0011));
    dir_rows.push_back(cfg_row(CFG_TARGET, 16'd0));
    dir_rows.push_back(byte_row(TAB_CHAR, 1'b1, 13'd1));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG) write_reg(dir_rows[k].reg_idx, dir_rows[k].data);
      else repeat (dir_rows[k].reps)
        send_byte(dir_rows[k].b, dir_rows[k].eol, dir_rows[k].typed, dir_rows[k].want);
    end
    directed_items = items_sent;

    // Random lines: mostly well-formed UTF-8, some noise and truncated endings
    while (rand_items < RANDOM_ITEMS) begin
      if ($urandom_range(7) == 0) begin
        if ($urandom_range(1) == 0) write_reg(CFG_TAB_STOP, COL_W'($urandom_range(0, 65535)));
        else write_reg(CFG_TARGET, pick_target());
      end
      line_bytes.delete();
      n_chars = ($urandom_range(39) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 20);
      for (int c = 0; c < n_chars; c++) begin
        kind = $urandom_range(99);
        if (kind < 35) begin
          line_bytes.push_back(8'($urandom_range(0, 127)));
        end else if (kind < 50) begin
          line_bytes.push_back(TAB_CHAR);
        end else if (kind < 65) begin
          line_bytes.push_back(8'hC0 | 8'($urandom_range(0, 31)));
          line_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end else if (kind < 77) begin
          line_bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
          repeat (2) line_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end else if (kind < 89) begin
          line_bytes.push_back(8'hF0 | 8'($urandom_range(0, 7)));
          repeat (3) line_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end else begin
          line_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end
      // cut the tail now and then so lines end inside a character
      if ($urandom_range(9) == 0 && line_bytes.size() > 3) begin
        cut = $urandom_range(1, 2);
        repeat (cut) void'(line_bytes.pop_back());
      end
      foreach (line_bytes[i]) begin
        if (i > 0 && $urandom_range(99) == 0) write_reg(CFG_TARGET, pick_target());
        send_byte(line_bytes[i], i == line_bytes.size() - 1, 1'b0, none);
        rand_items++;
        no_idle = (rand_items >= QUIET_FIRST && rand_items < QUIET_LAST);
        if (rand_items == HOLD_AT) hold_request = 1'b1;
        if (rand_items >= PAUSE_AT && !pause_done) begin
          pause_done = 1'b1;
          drain();
        end
      end
    end

    // Wind down and report
    drain();
    $display("Sent %0d items (%0d directed, %0d random) in %0d lines with %0d register writes",
             items_sent, directed_items, rand_items, lines_sent, cfg_writes);
    $display("Checked %0d results, %0d mismatches, %0d still expected",
             results_checked, mismatches, expected_columns.size());
    if (mismatches == 0 && expected_columns.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
